[hw/rtl/mapping_page_cache_lru_top_defines.svh]
// Assertion macros shared by the checker of the mapping page cache.
// Stands alone; included by the files that carry assertions.
`ifndef MAPPING_PAGE_CACHE_LRU_TOP_DEFINES_SVH
`define MAPPING_PAGE_CACHE_LRU_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mpc_pkg.sv]
// Shared constants, beat layouts and controller command type of the mapping page cache.
// No dependencies.
package mpc_pkg;

    // Bank, slot and entry counts are powers of two, so the page number splits by bit fields.
    localparam int BANKS                = 4;
    localparam int SLOTS_PER_BANK       = 4;
    localparam int ENTRIES_PER_MAP_PAGE = 8;
    localparam int PAGE_NUMBER_BITS     = 20;

    localparam int BANK_W   = $clog2(BANKS);
    localparam int SLOT_W   = $clog2(SLOTS_PER_BANK);
    localparam int OFFSET_W = $clog2(ENTRIES_PER_MAP_PAGE);
    localparam int TAG_W    = 15;
    localparam int AGE_W    = 16;
    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Result beat layout.
    localparam int OUT_BANK_LSB   = 0;
    localparam int OUT_SLOT_LSB   = OUT_BANK_LSB + BANK_W;
    localparam int OUT_HIT_BIT    = OUT_SLOT_LSB + SLOT_W;
    localparam int OUT_OFFSET_LSB = OUT_HIT_BIT + 1;
    localparam int OUT_PAGE_LSB   = OUT_OFFSET_LSB + OFFSET_W;
    localparam int OUT_WB_BIT     = OUT_PAGE_LSB + TAG_W;
    localparam int OUT_EV_LSB     = OUT_WB_BIT + 1;

    typedef struct packed {
        logic load;
        logic lookup;
        logic update;
    } mpc_cmd_t;

endpackage

[hw/rtl/mpc_ctrl.sv]
// Sequencer of the mapping page cache: accept, lookup, update and result handshake.
// Depends on mpc_pkg.
module mpc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output mpc_pkg::mpc_cmd_t cmd
);
    import mpc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    // The result register can take a new beat when empty or emptying this cycle.
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cmd.load   = s_tvalid && s_tready_reg;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.update = (state_reg == ST_UPDATE) && out_free;

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_UPDATE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready_reg) begin
                        state_reg    <= ST_LOOKUP;
                        s_tready_reg <= 1'b0;
                    end else begin
                        s_tready_reg <= 1'b1;
                    end
                end
                ST_LOOKUP: begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (out_free) begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg    <= ST_IDLE;
                    s_tready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

[hw/rtl/mpc_datapath.sv]
// Slot state, tag lookup, victim choice, aging and result register of the mapping page cache.
// Depends on mpc_pkg.
module mpc_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mpc_pkg::mpc_cmd_t               cmd,
    input  logic [mpc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic [mpc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import mpc_pkg::*;

    logic [PAGE_NUMBER_BITS-1:0] lp_reg;
    logic                        dirty_req_reg;
    logic                        hit_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic [M_TDATA_W-1:0]        m_tdata_reg;

    logic [TAG_W-1:0] slot_tag_reg   [BANKS][SLOTS_PER_BANK];
    logic             slot_valid_reg [BANKS][SLOTS_PER_BANK];
    logic             slot_dirty_reg [BANKS][SLOTS_PER_BANK];
    logic [AGE_W-1:0] slot_age_reg   [BANKS][SLOTS_PER_BANK];

    logic [BANK_W-1:0]   bank;
    logic [OFFSET_W-1:0] offset;
    logic [TAG_W-1:0]    req_page;

    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] empty_slot;
    logic [SLOT_W-1:0] victim_slot;
    logic [SLOT_W-1:0] slot_next;
    logic              any_hit;
    logic              any_empty;
    logic [AGE_W-1:0]  best_age;

    logic             writeback;
    logic [TAG_W-1:0] evicted_page;

    assign bank     = lp_reg[BANK_W-1:0];
    assign offset   = lp_reg[BANK_W+OFFSET_W-1:BANK_W];
    assign req_page = TAG_W'(lp_reg >> (BANK_W + OFFSET_W));

    // Lowest matching slot, highest empty slot, and the oldest slot with ties to the lowest.
    always_comb begin
        hit_slot    = '0;
        empty_slot  = '0;
        any_hit     = 1'b0;
        any_empty   = 1'b0;
        for (int i = SLOTS_PER_BANK - 1; i >= 0; i--) begin
            if (slot_valid_reg[bank][i] && (slot_tag_reg[bank][i] == req_page)) begin
                hit_slot = SLOT_W'(i);
                any_hit  = 1'b1;
            end
        end
        for (int i = 0; i < SLOTS_PER_BANK; i++) begin
            if (!slot_valid_reg[bank][i]) begin
                empty_slot = SLOT_W'(i);
                any_empty  = 1'b1;
            end
        end
        best_age    = slot_age_reg[bank][0];
        victim_slot = '0;
        for (int i = 1; i < SLOTS_PER_BANK; i++) begin
            if (slot_age_reg[bank][i] > best_age) begin
                best_age    = slot_age_reg[bank][i];
                victim_slot = SLOT_W'(i);
            end
        end
        if (any_hit) begin
            slot_next = hit_slot;
        end else if (any_empty) begin
            slot_next = empty_slot;
        end else begin
            slot_next = victim_slot;
        end
    end

    assign writeback    = !hit_reg && slot_valid_reg[bank][slot_reg]
                          && slot_dirty_reg[bank][slot_reg];
    assign evicted_page = writeback ? slot_tag_reg[bank][slot_reg] : '0;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lp_reg        <= s_tdata[PAGE_NUMBER_BITS-1:0];
            dirty_req_reg <= s_tdata[PAGE_NUMBER_BITS];
        end
        if (cmd.lookup) begin
            hit_reg  <= any_hit;
            slot_reg <= slot_next;
        end
        if (cmd.update) begin
            m_tdata_reg <= {1'b0, evicted_page, writeback, req_page, offset,
                            hit_reg, slot_reg, bank};
            if (!hit_reg) begin
                slot_tag_reg[bank][slot_reg] <= req_page;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < BANKS; b++) begin
                for (int i = 0; i < SLOTS_PER_BANK; i++) begin
                    slot_valid_reg[b][i] <= 1'b0;
                    slot_dirty_reg[b][i] <= 1'b0;
                    slot_age_reg[b][i]   <= '0;
                end
            end
        end else if (cmd.update) begin
            if (hit_reg) begin
                if (dirty_req_reg) begin
                    slot_dirty_reg[bank][slot_reg] <= 1'b1;
                end
            end else begin
                slot_valid_reg[bank][slot_reg] <= 1'b1;
                slot_dirty_reg[bank][slot_reg] <= dirty_req_reg;
            end
            for (int i = 0; i < SLOTS_PER_BANK; i++) begin
                if (SLOT_W'(i) == slot_reg) begin
                    slot_age_reg[bank][i] <= '0;
                end else if (slot_age_reg[bank][i] != AGE_MAX) begin
                    slot_age_reg[bank][i] <= slot_age_reg[bank][i] + 1'b1;
                end
            end
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

[hw/rtl/mapping_page_cache_lru_top.sv]
// Channel    | Direction | Beat contents (lowest bit first)
// s_axis     | in        | logical_page[19:0], make_dirty[20], zero pad to 24 bits
// m_axis     | out       | bank_index, slot_index, hit, entry_offset, mapping_page,
//            |           | writeback, evicted_page, zero pad to 40 bits
//
// Each request passes through accept, tag compare and victim choice over the bank's slots,
// and an update step that updates the slot state and loads the result.
// The next request is accepted while that result waits in the output register.
// A stalled output holds the update step until the output register frees.
// aresetn is synchronous and active low; it empties every slot and clears all ages.
// Depends on mpc_pkg, mpc_ctrl and mpc_datapath.
module mapping_page_cache_lru_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // logical_page[19:0], make_dirty[20], pad[23:21]
    input  logic [mpc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bank_index[1:0], slot_index[3:2], hit[4], entry_offset[7:5], mapping_page[22:8],
    // writeback[23], evicted_page[38:24], pad[39]
    output logic [mpc_pkg::M_TDATA_W-1:0] m_tdata
);
    import mpc_pkg::*;

    mpc_cmd_t cmd;

    mpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mpc_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

[hw/rtl/mpc_checker.sv]
// Port-level checks of the mapping page cache, bound to the top level.
// Depends on mpc_pkg and mapping_page_cache_lru_top_defines.svh.
`include "mapping_page_cache_lru_top_defines.svh"

module mpc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mpc_pkg::M_TDATA_W-1:0] m_tdata
);
    import mpc_pkg::*;

    logic s_beat;
    logic m_hit;
    logic m_wb;
    logic [TAG_W-1:0] m_ev;

    assign s_beat = s_tvalid && s_tready;
    assign m_hit  = m_tdata[OUT_HIT_BIT];
    assign m_wb   = m_tdata[OUT_WB_BIT];
    assign m_ev   = m_tdata[OUT_EV_LSB+TAG_W-1:OUT_EV_LSB];

    // A held result beat keeps its contents.
    `MPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    // Only one request is worked on at a time.
    `MPC_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_beat, !s_tready, "request accepted while another is in work")
    // A result cannot appear in the cycle right after its request.
    `MPC_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_beat, !$rose(m_tvalid), "result appeared before lookup finished")
    // Write-back comes only from a miss, and the evicted page is zero without one.
    `MPC_ASSERT_SAME(a_wb_consistent, aclk, aresetn, m_tvalid, (!m_wb || !m_hit) && (m_wb || (m_ev == '0)), "write-back fields inconsistent")

endmodule

bind mapping_page_cache_lru_top mpc_checker u_mpc_checker (.*);
